### rtl/core/tspsa_pkg.sv
// Shared constants and types for the transport-stream packet sync aligner.
package tspsa_pkg;

  // Packet length in bytes, sync byte included.
  localparam int PACKET_LEN = 188;
  localparam int PTR_W = $clog2(PACKET_LEN);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(PACKET_LEN - 1);

  // Default sync byte, ASCII 'G'.
  localparam logic [7:0] SYNC_RESET = 8'h47;

  // One result item as it leaves the framer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       first;
    logic       last;
  } result_t;

  // Framer status visible to the top level.
  typedef struct packed {
    logic             locked;
    logic [PTR_W-1:0] byte_pos;
  } frm_status_t;

endpackage

### rtl/core/ts_packet_sync_aligner_unit.sv
// Top level of the transport-stream packet sync aligner.
//
// The block takes one transport-stream byte per item and runs it through a
// delay line one packet (188 bytes) long, held in a RAM. While hunting it
// drops bytes until the byte leaving the line and the byte entering it both
// equal sync_value; it then locks and passes the delayed bytes on, marking
// the packet's first and last bytes. A packet is released only when the
// next packet's sync byte enters as its own sync byte leaves, so output
// trails input by exactly one packet. On a mismatch at a packet start the
// unconfirmed packet is dropped and the block hunts again. After reset the
// first 188 items only fill the line and produce nothing; no clearing pass
// is needed. For each input item the RAM read for the next position is
// issued alongside the write for the current one, and a single output
// register lets a new item enter in the same cycle in which the waiting
// result is taken, so one item per cycle is sustained whenever the output
// side keeps up. An accepted item's result is in the result register in
// the cycle after it is accepted.
// sync_value is written through its own port and takes effect at the next
// packet start check.
module ts_packet_sync_aligner_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packet_byte,
  output logic       first_of_packet,
  output logic       last_of_packet,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] sync_value
);

  logic                  in_fire;
  logic [7:0]            sync_reg;
  logic [7:0]            leaving;
  logic                  primed;
  tspsa_pkg::result_t    res;
  tspsa_pkg::frm_status_t frm_status;

  // A new item may enter when the result register is empty or is being
  // emptied in this cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg <= tspsa_pkg::SYNC_RESET;
    end else if (cfg_valid) begin
      sync_reg <= sync_value;
    end
  end

  tspsa_delay_line u_delay (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .wr_byte (stream_byte),
    .leaving (leaving),
    .primed  (primed)
  );

  tspsa_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_fire),
    .primed     (primed),
    .leaving    (leaving),
    .incoming   (stream_byte),
    .sync_value (sync_reg),
    .res        (res),
    .status     (frm_status)
  );

  // Result register: loaded on every accepted item, which either carries a
  // packet byte or leaves the register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      packet_byte     <= res.data;
      first_of_packet <= res.first;
      last_of_packet  <= res.last;
    end
  end

  // A packet never starts and ends on the same byte.
  assert property (@(posedge clk) disable iff (rst)
    !(out_valid && first_of_packet && last_of_packet))
    else $error("first and last marks on the same byte");

  // Nothing may be produced before the delay line has been filled once.
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> primed)
    else $error("result produced before the delay line was filled");

  // Releasing a packet's first byte must leave the framer locked.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.valid && res.first) |=> frm_status.locked)
    else $error("framer not locked after a packet start");

  // While hunting, the packet position counter stays at zero.
  assert property (@(posedge clk) disable iff (rst)
    !frm_status.locked |-> (frm_status.byte_pos == '0))
    else $error("packet position moved while hunting");

endmodule

### rtl/core/tspsa_delay_line.sv
// Packet-long byte delay line built on a single-port-per-direction RAM.
module tspsa_delay_line (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] wr_byte,
  output logic [7:0] leaving,
  output logic       primed
);

  logic [7:0]                  mem [tspsa_pkg::PACKET_LEN];
  logic [tspsa_pkg::PTR_W-1:0] ptr;
  logic [tspsa_pkg::PTR_W-1:0] ptr_next;
  logic                        wrap;

  assign wrap     = (ptr == tspsa_pkg::LAST_POS);
  assign ptr_next = wrap ? '0 : ptr + 1'b1;

  // The byte for the next position is fetched while the current one is
  // overwritten, so it is ready in the cycle of the following item.
  always_ff @(posedge clk) begin
    if (advance) begin
      mem[ptr] <= wr_byte;
      leaving  <= mem[ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      primed <= 1'b0;
    end else if (advance) begin
      ptr <= ptr_next;
      if (wrap) begin
        primed <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/tspsa_framer.sv
// Lock tracking and packet position counting for the sync aligner.
module tspsa_framer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   primed,
  input  logic [7:0]             leaving,
  input  logic [7:0]             incoming,
  input  logic [7:0]             sync_value,
  output tspsa_pkg::result_t     res,
  output tspsa_pkg::frm_status_t status
);

  logic                        locked;
  logic [tspsa_pkg::PTR_W-1:0] byte_pos;
  logic                        at_start;
  logic                        match;
  logic                        at_last;

  assign at_start = !locked || (byte_pos == '0);
  assign match    = (leaving == sync_value) && (incoming == sync_value);
  assign at_last  = (byte_pos == tspsa_pkg::LAST_POS);

  always_comb begin
    res.data  = leaving;
    res.first = at_start;
    res.last  = !at_start && at_last;
    res.valid = primed && (!at_start || match);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked   <= 1'b0;
      byte_pos <= '0;
    end else if (advance && primed) begin
      if (at_start) begin
        locked   <= match;
        byte_pos <= match ? tspsa_pkg::PTR_W'(1) : '0;
      end else begin
        byte_pos <= at_last ? '0 : byte_pos + 1'b1;
      end
    end
  end

  assign status.locked   = locked;
  assign status.byte_pos = byte_pos;

endmodule
